@@ rtl/sprite_part_to_oam_builder_macros.svh @@
// Assertion macros used by the list walker (spob_engine) of the sprite part to OAM builder.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef SPRITE_PART_TO_OAM_BUILDER_MACROS_SVH
`define SPRITE_PART_TO_OAM_BUILDER_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a property holds at every rising clock edge outside reset.
`define SPOB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
// Checks that a condition never occurs outside reset.
`define SPOB_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define SPOB_ASSERT(lbl, clk, rst_n, prop)
`define SPOB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/spob_pkg.sv @@
// Types and constants of the sprite part to OAM builder.
// Used by every module of the block; depends on nothing.
package spob_pkg;

    // Item kinds on the input side.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_PART  = 1'b1;

    // Result kinds on the output side.
    localparam logic OUT_AFFINE = 1'b0;
    localparam logic OUT_OBJECT = 1'b1;

    // Header decoding.
    localparam logic [15:0] MARKER_HI     = 16'hFFFF;
    localparam logic [31:0] TERM_HEADER   = 32'd1;
    localparam int          AFFINE_EN_BIT = 8;
    localparam int          SNAP_SHIFT    = 25;

    // Screen clipping.
    localparam logic signed [16:0] X_MAX   = 17'sd256;
    localparam logic signed [16:0] Y_MAX   = 17'sd160;
    localparam logic signed [16:0] POS_MIN = -17'sd64;
    localparam logic [8:0]         X_HIDE  = 9'h180;

    localparam logic [15:0] ATTR2_MASK = 16'hF3FF;

    // List walking mode.
    typedef enum logic [1:0] {
        MODE_AFFINE = 2'd0,
        MODE_OBJECT = 2'd1,
        MODE_DONE   = 2'd2
    } t_mode;

    typedef struct packed {
        logic               kind;
        logic               first_of_sprite;
        logic [31:0]        header;
        logic [15:0]        word_a;
        logic signed [15:0] word_b;
        logic signed [15:0] word_c;
        logic [15:0]        word_d;
        logic signed [15:0] sprite_x;
        logic signed [15:0] sprite_y;
        logic [31:0]        sprite_attr01;
        logic [15:0]        sprite_attr2;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [31:0] attr01;
        logic [15:0] attr2;
        logic [15:0] aff_pa;
        logic [15:0] aff_pb;
        logic [15:0] aff_pc;
        logic [15:0] aff_pd;
        logic [6:0]  affine_slot;
    } t_out_item;

endpackage

@@ rtl/spob_in_reg.sv @@
// Input register stage of the sprite part to OAM builder.
// Depends on spob_pkg for the input item type.
module spob_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  spob_pkg::t_in_item i_item,
    output logic              o_ready,
    input  logic              i_take,
    output logic              o_valid,
    output spob_pkg::t_in_item o_item
);

    logic               r_valid;
    spob_pkg::t_in_item r_item;

    // The register frees up when its item moves on in the same cycle.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/spob_engine.sv @@
// List walker of the sprite part to OAM builder: counters, mode and result logic.
// Depends on spob_pkg and the assertion macros header.
`include "sprite_part_to_oam_builder_macros.svh"
module spob_engine #(
    parameter int OAM_ENTRIES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  spob_pkg::t_in_item  i_item,
    input  logic                i_out_free,
    output logic                o_take,
    output logic                o_res_valid,
    output spob_pkg::t_out_item o_res
);

    localparam int CntW = $clog2(OAM_ENTRIES + 1);

    spob_pkg::t_mode r_mode, n_mode;
    logic [15:0]     r_left, n_left;
    logic [6:0]      r_counter, n_counter;
    logic [6:0]      r_snap, n_snap;
    logic [CntW-1:0] r_entry_count, n_entry_count;

    // Values after the start-of-sprite decode.
    spob_pkg::t_mode w_mode;
    logic [15:0]     w_left;
    logic [6:0]      w_snap;
    logic            w_marker;

    logic signed [16:0] w_x, w_y;
    logic               w_hide;
    logic [8:0]         w_x_bits;
    logic [31:0]        w_base;
    logic [31:0]        w_attr01;
    logic [15:0]        w_attr2;
    logic [15:0]        w_left_dec;

    assign o_take = i_valid && i_out_free;

    // Object position, clipping and attribute composition.
    always_comb begin
        w_x      = 17'(i_item.word_b) + 17'(i_item.sprite_x);
        w_y      = 17'(i_item.word_c) + 17'(i_item.sprite_y);
        w_hide   = (w_x > spob_pkg::X_MAX) || (w_x < spob_pkg::POS_MIN)
                || (w_y > spob_pkg::Y_MAX) || (w_y < spob_pkg::POS_MIN);
        w_x_bits = w_hide ? spob_pkg::X_HIDE : w_x[8:0];
        w_base   = i_item.sprite_attr01;
        if (i_item.header[spob_pkg::AFFINE_EN_BIT]) begin
            w_base = i_item.sprite_attr01 + (32'(w_snap) << spob_pkg::SNAP_SHIFT);
        end
        w_attr01 = (i_item.header + w_base) | {7'd0, w_x_bits, 8'd0, w_y[7:0]};
        w_attr2  = (i_item.word_a & spob_pkg::ATTR2_MASK) + i_item.sprite_attr2;
    end

    // Start of a sprite reloads the mode, the affine count and the snapshot.
    always_comb begin
        w_marker = i_item.header[31:16] == spob_pkg::MARKER_HI;
        w_mode   = r_mode;
        w_left   = r_left;
        w_snap   = r_snap;
        if (i_item.first_of_sprite) begin
            w_snap = r_counter;
            w_mode = spob_pkg::MODE_OBJECT;
            w_left = 16'd0;
            if (w_marker && (i_item.header[15:0] != 16'd0)) begin
                w_mode = spob_pkg::MODE_AFFINE;
                w_left = i_item.header[15:0];
            end
        end
        w_left_dec = w_left - 16'd1;
    end

    // Next state and result for the item in the input register.
    always_comb begin
        n_mode        = r_mode;
        n_left        = r_left;
        n_counter     = r_counter;
        n_snap        = r_snap;
        n_entry_count = r_entry_count;
        o_res_valid   = 1'b0;
        o_res         = '0;
        if (i_item.kind == spob_pkg::KIND_FRAME) begin
            n_mode        = spob_pkg::MODE_DONE;
            n_left        = 16'd0;
            n_counter     = 7'd0;
            n_entry_count = '0;
        end else begin
            n_snap = w_snap;
            n_mode = w_mode;
            n_left = w_left;
            unique case (w_mode)
                spob_pkg::MODE_AFFINE: begin
                    o_res_valid       = 1'b1;
                    o_res.out_kind    = spob_pkg::OUT_AFFINE;
                    o_res.aff_pa      = i_item.word_a;
                    o_res.aff_pb      = i_item.word_b;
                    o_res.aff_pc      = i_item.word_c;
                    o_res.aff_pd      = i_item.word_d;
                    o_res.affine_slot = r_counter;
                    n_counter         = r_counter + 7'd1;
                    n_left            = w_left_dec;
                    if (w_left_dec == 16'd0) begin
                        n_mode = spob_pkg::MODE_OBJECT;
                    end
                end
                spob_pkg::MODE_OBJECT: begin
                    if ((i_item.header == spob_pkg::TERM_HEADER)
                        || (r_entry_count >= CntW'(OAM_ENTRIES))) begin
                        n_mode = spob_pkg::MODE_DONE;
                    end else begin
                        o_res_valid    = 1'b1;
                        o_res.out_kind = spob_pkg::OUT_OBJECT;
                        o_res.attr01   = w_attr01;
                        o_res.attr2    = w_attr2;
                        n_entry_count  = r_entry_count + CntW'(1);
                    end
                end
                default: begin
                    // List is finished: the item is dropped.
                end
            endcase
        end
        // Only a valid item in the input register changes anything.
        if (!i_valid) begin
            o_res_valid = 1'b0;
        end
    end

    // State update when the item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= spob_pkg::MODE_DONE;
            r_left        <= 16'd0;
            r_counter     <= 7'd0;
            r_snap        <= 7'd0;
            r_entry_count <= '0;
        end else if (o_take) begin
            r_mode        <= n_mode;
            r_left        <= n_left;
            r_counter     <= n_counter;
            r_snap        <= n_snap;
            r_entry_count <= n_entry_count;
        end
    end

    // An object entry is only produced while the table has room.
    `SPOB_ASSERT(a_room_for_entry, i_clk, i_rst_n,
        (o_take && o_res_valid && (o_res.out_kind == spob_pkg::OUT_OBJECT))
        |-> (r_entry_count < CntW'(OAM_ENTRIES)))
    // A frame start leaves cleared counters and a finished list behind.
    `SPOB_ASSERT(a_frame_clears, i_clk, i_rst_n,
        (o_take && (i_item.kind == spob_pkg::KIND_FRAME))
        |=> ((r_entry_count == '0) && (r_counter == 7'd0)
            && (r_mode == spob_pkg::MODE_DONE)))
    // Each affine group moves the slot counter on by exactly one.
    `SPOB_ASSERT(a_slot_advance, i_clk, i_rst_n,
        (o_take && o_res_valid && (o_res.out_kind == spob_pkg::OUT_AFFINE))
        |=> (r_counter == ($past(r_counter) + 7'd1)))
    // The affine mode is never left with a zero remaining count.
    `SPOB_NEVER(a_affine_count, i_clk, i_rst_n,
        (r_mode == spob_pkg::MODE_AFFINE) && (r_left == 16'd0))

endmodule

@@ rtl/spob_out_reg.sv @@
// Result register stage of the sprite part to OAM builder.
// Depends on spob_pkg for the result item type.
module spob_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  spob_pkg::t_out_item i_res,
    output logic                o_free,
    output logic                o_valid,
    output spob_pkg::t_out_item o_res,
    input  logic                i_ready
);

    logic                r_valid;
    spob_pkg::t_out_item r_res;

    // Room for a new result when empty or when the held one is taken now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/sprite_part_to_oam_builder.sv @@
// Sprite part to OAM builder, top level: input register, list walker, result register.
// An accepted item is registered in the input register, and its result, if any, in the result register.
// Throughput: one item per cycle; the input register drains into the result
// register whenever that register is empty or being read in the same cycle.
// Reset (synchronous, active low) empties both registers and sets the list done
// with all counters zero. Depends on spob_pkg, spob_in_reg, spob_engine, spob_out_reg.
module sprite_part_to_oam_builder #(
    parameter int OAM_ENTRIES = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  spob_pkg::t_in_item  i_in_data,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output spob_pkg::t_out_item o_out_data,
    input  logic                i_out_ready
);

    logic                w_stage_valid;
    spob_pkg::t_in_item  w_stage_item;
    logic                w_take;
    logic                w_out_free;
    logic                w_res_valid;
    spob_pkg::t_out_item w_res;

    // Input register.
    spob_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_ready (o_in_ready),
        .i_take  (w_take),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item)
    );

    // List walker and result composition.
    spob_engine #(
        .OAM_ENTRIES (OAM_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stage_valid),
        .i_item      (w_stage_item),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register.
    spob_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take && w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .o_res   (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule

@@ tb/sprite_part_to_oam_builder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sprite part to OAM builder: a directed table, then random frames.
// Depends on spob_pkg and sprite_part_to_oam_builder; needs nothing else.
module sprite_part_to_oam_builder_tb;

    localparam int OAM_LIMIT   = 128;
    localparam int ITEM_TARGET = 1170;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    localparam logic signed [16:0] CLIP_X_HI = 17'sd256;
    localparam logic signed [16:0] CLIP_Y_HI = 17'sd160;
    localparam logic signed [16:0] CLIP_LO   = -17'sd64;
    localparam logic [8:0]         HIDDEN_X  = 9'h180;
    localparam logic [31:0]        END_LIST  = 32'd1;
    localparam logic [15:0]        AFF_MARK  = 16'hFFFF;

    typedef struct {
        spob_pkg::t_in_item  item;
        bit                  typed;
        spob_pkg::t_out_item res;
    } t_dir_row;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    spob_pkg::t_in_item  in_data   = '0;
    logic                in_ready;
    logic                out_valid;
    spob_pkg::t_out_item out_data;
    logic                out_ready = 1'b0;

    // Shadow of the block's list walker; reset values match the block after reset.
    spob_pkg::t_mode walk_mode     = spob_pkg::MODE_DONE;
    logic [15:0]     aff_remaining = '0;
    logic [6:0]      slot_ctr      = '0;
    logic [6:0]      slot_snap     = '0;
    logic [7:0]      entries       = '0;

    spob_pkg::t_out_item pending_entries[$];
    t_dir_row   dir_rows[$];
    int errors       = 0;
    int n_items      = 0;
    int n_aff_groups = 0;
    int n_obj_entries = 0;
    int n_full_ends  = 0;
    int n_slot_wraps = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold      = 0;
    int idle_cycles  = 0;

    sprite_part_to_oam_builder #(
        .OAM_ENTRIES(OAM_LIMIT)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_ready(out_ready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Works out the entry that one accepted item produces, if any.
    function automatic bit predict_oam_entry(input spob_pkg::t_in_item it,
                                             output spob_pkg::t_out_item res,
                                             output bit ignored);
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic [8:0]         xbits;
        logic [31:0]        base;
        res = '0;
        ignored = 1'b0;
        if (it.kind == spob_pkg::KIND_FRAME) begin
            slot_ctr = '0;
            entries = '0;
            aff_remaining = '0;
            walk_mode = spob_pkg::MODE_DONE;
            return 1'b0;
        end
        if (it.first_of_sprite) begin
            slot_snap = slot_ctr;
            walk_mode = spob_pkg::MODE_OBJECT;
            aff_remaining = '0;
            if (it.header[31:16] == AFF_MARK) begin
                aff_remaining = it.header[15:0];
                if (aff_remaining != 0) walk_mode = spob_pkg::MODE_AFFINE;
            end
        end
        // Affine records pass their four words through untouched.
        if (walk_mode == spob_pkg::MODE_AFFINE) begin
            res.out_kind = spob_pkg::OUT_AFFINE;
            res.aff_pa = it.word_a;
            res.aff_pb = it.word_b;
            res.aff_pc = it.word_c;
            res.aff_pd = it.word_d;
            res.affine_slot = slot_ctr;
            if (slot_ctr == 7'h7F) n_slot_wraps++;
            slot_ctr = slot_ctr + 7'd1;
            aff_remaining = aff_remaining - 16'd1;
            if (aff_remaining == 0) walk_mode = spob_pkg::MODE_OBJECT;
            n_aff_groups++;
            return 1'b1;
        end
        if (walk_mode == spob_pkg::MODE_OBJECT) begin
            if (it.header == END_LIST || entries >= OAM_LIMIT) begin
                if (it.header != END_LIST) n_full_ends++;
                walk_mode = spob_pkg::MODE_DONE;
                return 1'b0;
            end
            px = {it.word_b[15], it.word_b} + {it.sprite_x[15], it.sprite_x};
            py = {it.word_c[15], it.word_c} + {it.sprite_y[15], it.sprite_y};
            // Off-screen in either axis hides the object through x alone.
            if (px > CLIP_X_HI || px < CLIP_LO || py > CLIP_Y_HI || py < CLIP_LO)
                xbits = HIDDEN_X;
            else
                xbits = px[8:0];
            base = it.sprite_attr01;
            if (it.header[8]) base = base + {slot_snap, 25'b0};
            res.out_kind = spob_pkg::OUT_OBJECT;
            res.attr01 = (it.header + base) | {7'b0, xbits, 16'b0} | {24'b0, py[7:0]};
            res.attr2 = (it.word_a & 16'hF3FF) + it.sprite_attr2;
            entries = entries + 8'd1;
            n_obj_entries++;
            return 1'b1;
        end
        ignored = 1'b1;
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // Screen positions and part offsets cluster around the clipping window.
    function automatic logic [15:0] rnd_pos();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 400) - 100);
    endfunction

    function automatic logic [15:0] rnd_off();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 120) - 60);
    endfunction

    function automatic spob_pkg::t_in_item rand_item();
        spob_pkg::t_in_item r;
        r.kind = 1'($urandom);
        r.first_of_sprite = 1'($urandom);
        r.header = $urandom;
        r.word_a = 16'($urandom);
        r.word_b = 16'($urandom);
        r.word_c = 16'($urandom);
        r.word_d = 16'($urandom);
        r.sprite_x = 16'($urandom);
        r.sprite_y = 16'($urandom);
        r.sprite_attr01 = $urandom;
        r.sprite_attr2 = 16'($urandom);
        return r;
    endfunction

    function automatic spob_pkg::t_in_item mk_part(input bit first, input logic [31:0] hdr,
                                         input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d,
                                         input logic [15:0] sx, input logic [15:0] sy,
                                         input logic [31:0] b01, input logic [15:0] b2);
        spob_pkg::t_in_item r;
        r.kind = spob_pkg::KIND_PART;
        r.first_of_sprite = first;
        r.header = hdr;
        r.word_a = a;
        r.word_b = b;
        r.word_c = c;
        r.word_d = d;
        r.sprite_x = sx;
        r.sprite_y = sy;
        r.sprite_attr01 = b01;
        r.sprite_attr2 = b2;
        return r;
    endfunction

    function automatic spob_pkg::t_in_item frame_item();
        spob_pkg::t_in_item r;
        r = rand_item();
        r.kind = spob_pkg::KIND_FRAME;
        return r;
    endfunction

    function automatic spob_pkg::t_out_item obj_res(input logic [31:0] a01,
                                                    input logic [15:0] a2);
        spob_pkg::t_out_item r;
        r = '0;
        r.out_kind = spob_pkg::OUT_OBJECT;
        r.attr01 = a01;
        r.attr2 = a2;
        return r;
    endfunction

    function automatic spob_pkg::t_out_item aff_res(input logic [15:0] pa,
                                                    input logic [15:0] pb,
                                                    input logic [15:0] pc,
                                                    input logic [15:0] pd,
                                                    input logic [6:0] slot);
        spob_pkg::t_out_item r;
        r = '0;
        r.out_kind = spob_pkg::OUT_AFFINE;
        r.aff_pa = pa;
        r.aff_pb = pb;
        r.aff_pc = pc;
        r.aff_pd = pd;
        r.affine_slot = slot;
        return r;
    endfunction

    // Presents one item after an optional gap and waits until it is accepted.
    task automatic send_item(input spob_pkg::t_in_item it, input bit typed,
                             input spob_pkg::t_out_item typed_res);
        int                  gap;
        spob_pkg::t_out_item res;
        bit                  has_res;
        bit                  ignored;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        has_res = predict_oam_entry(it, res, ignored);
        if (!ignored) n_items++;
        if (has_res) pending_entries.push_back(typed ? typed_res : res);
    endtask

    // Holds the input side off until every outstanding entry has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_entries.size() != 0);
    endtask

    task automatic send_part(input spob_pkg::t_in_item sp, input bit first,
                             input logic [31:0] hdr);
        send_item(mk_part(first, hdr, 16'($urandom), rnd_off(), rnd_off(), 16'($urandom),
                          sp.sprite_x, sp.sprite_y, sp.sprite_attr01, sp.sprite_attr2),
                  1'b0, '0);
    endtask

    // One sprite: an optional affine group, object records, then usually a terminator.
    task automatic run_sprite(input bit heavy);
        spob_pkg::t_in_item sp;
        int                 r;
        int                 cnt;
        int                 n_obj;
        logic [31:0]        hdr;
        sp = rand_item();
        sp.sprite_x = rnd_pos();
        sp.sprite_y = rnd_pos();
        r = $urandom_range(0, 99);
        if (heavy) cnt = $urandom_range(20, 40);
        else if (r < 55) cnt = -1;
        else if (r < 80) cnt = $urandom_range(1, 3);
        else if (r < 88) cnt = 0;
        else cnt = $urandom_range(4, 24);
        n_obj = heavy ? $urandom_range(20, 35) : $urandom_range(0, 6);
        if (cnt < 0) begin
            hdr = $urandom;
            if (hdr[31:16] == AFF_MARK) hdr[31] = 1'b0;
            if (hdr == END_LIST) hdr = '0;
        end else begin
            hdr = {AFF_MARK, 16'(cnt)};
        end
        send_part(sp, 1'b1, hdr);
        // Now and then the frame restarts in the middle of a sprite.
        if (!heavy && $urandom_range(0, 24) == 0) send_item(frame_item(), 1'b0, '0);
        for (int i = 1; i < cnt; i++)
            send_part(sp, 1'b0, ($urandom_range(0, 3) == 0) ? END_LIST : $urandom);
        for (int i = 0; i < n_obj; i++) begin
            hdr = $urandom;
            if ($urandom_range(0, 15) == 0) hdr[31:16] = AFF_MARK;
            if (hdr == END_LIST) hdr = '0;
            send_part(sp, 1'b0, hdr);
        end
        if ($urandom_range(0, 9) < 7) send_part(sp, 1'b0, END_LIST);
    endtask

    // One frame of sprites with its own idle and stall mix.
    task automatic run_frame(input bit heavy);
        int start;
        int target;
        tx_idle_pct = pick_pct();
        rx_stall_pct = pick_pct();
        send_item(frame_item(), 1'b0, '0);
        start = n_items;
        target = heavy ? 300 : $urandom_range(10, 60);
        while (n_items - start < target) begin
            run_sprite(heavy);
            if (!heavy && $urandom_range(0, 9) == 0) send_item(rand_item(), 1'b0, '0);
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // Result side: check each accepted entry, then decide on the next cycle's ready.
    always @(posedge clk) begin
        spob_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_entries.size() == 0) begin
                $error("entry %h arrived with nothing outstanding", out_data);
                errors++;
            end else begin
                want = pending_entries.pop_front();
                cmp_field("out_kind", want.out_kind, out_data.out_kind);
                cmp_field("attr01", want.attr01, out_data.attr01);
                cmp_field("attr2", want.attr2, out_data.attr2);
                cmp_field("aff_pa", want.aff_pa, out_data.aff_pa);
                cmp_field("aff_pb", want.aff_pb, out_data.aff_pb);
                cmp_field("aff_pc", want.aff_pc, out_data.aff_pc);
                cmp_field("aff_pd", want.aff_pd, out_data.aff_pd);
                cmp_field("affine_slot", want.affine_slot, out_data.affine_slot);
            end
        end
        if (rx_hold != 0) begin
            out_ready <= 1'b0;
            rx_hold--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < rx_stall_pct) rx_hold = pick_gap();
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int frame_idx;
        // Directed rows; typed-in entries follow directly from the field values.
        dir_rows.push_back('{mk_part(1'b0, $urandom, 16'h1111, 16'h0, 16'h0, 16'h0, 16'h0,
                                     16'h0, 32'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{frame_item(), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b1, 32'hFFFF0002, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, aff_res(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 7'd0)});
        dir_rows.push_back('{mk_part(1'b0, END_LIST, 16'h0, 16'h0, 16'h0, 16'hFFFF,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, aff_res(16'h0, 16'h0, 16'h0, 16'hFFFF, 7'd1)});
        dir_rows.push_back('{mk_part(1'b0, 32'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, obj_res(32'h0, 16'hF3FF)});
        dir_rows.push_back('{mk_part(1'b1, 32'h100, 16'h0, 16'h0100, 16'h00A0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'hFFFF),
                             1'b1, obj_res(32'h050001A0, 16'hFFFF)});
        dir_rows.push_back('{mk_part(1'b0, 32'h0, 16'h0, 16'h0101, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, obj_res(32'h01800000, 16'h0)});
        dir_rows.push_back('{mk_part(1'b0, 32'h0, 16'h0, 16'hFFC0, 16'hFFC0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, obj_res(32'h01C000C0, 16'h0)});
        dir_rows.push_back('{mk_part(1'b0, 32'h0, 16'h0, 16'h0005, 16'h00A1, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, obj_res(32'h018000A1, 16'h0)});
        dir_rows.push_back('{mk_part(1'b0, 32'h0, 16'h0, 16'h7FFF, 16'h8000, 16'h0,
                                     16'h7FFF, 16'h8000, 32'h0, 16'h0),
                             1'b1, obj_res(32'h01800000, 16'h0)});
        dir_rows.push_back('{mk_part(1'b0, 32'hFFFFFE00, 16'h0C01, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h00000300, 16'hFFFF),
                             1'b1, obj_res(32'h00000100, 16'h0)});
        dir_rows.push_back('{mk_part(1'b0, END_LIST, 16'h0, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b0, $urandom, 16'h2222, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b1, 32'hFFFF0000, 16'h0, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, obj_res(32'hFFFF0000, 16'h0)});
        dir_rows.push_back('{mk_part(1'b1, 32'hFFFF0001, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, aff_res(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 7'd2)});
        dir_rows.push_back('{frame_item(), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b0, $urandom, 16'h3333, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b1, 32'h100, 16'($urandom), rnd_off(), rnd_off(),
                                     16'($urandom), rnd_pos(), rnd_pos(), $urandom,
                                     16'($urandom)), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b1, END_LIST, 16'h0, 16'h0, 16'h0, 16'h0,
                                     16'h0, 16'h0, 32'h0, 16'h0), 1'b0, '0});
        dir_rows.push_back('{mk_part(1'b1, 32'hFFFF0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'h0, 16'h0, 32'h0, 16'h0),
                             1'b1, aff_res(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0)});
        dir_rows.push_back('{mk_part(1'b0, 32'h100, 16'($urandom), rnd_off(), rnd_off(),
                                     16'($urandom), rnd_pos(), rnd_pos(), $urandom,
                                     16'($urandom)), 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        drain();

        // The first random frame is long enough to fill the table and wrap the slot counter.
        frame_idx = 0;
        while (n_items < ITEM_TARGET) begin
            run_frame(frame_idx == 0);
            frame_idx++;
            if (frame_idx % 5 == 0) drain();
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_entries.size() != 0) begin
            $error("%0d entries never arrived", pending_entries.size());
            errors++;
        end
        $display("Run covered %0d items in %0d frames: %0d affine groups, %0d object entries.",
                 n_items, frame_idx, n_aff_groups, n_obj_entries);
        $display("Lists ended by a full table: %0d; affine slot wraps: %0d.",
                 n_full_ends, n_slot_wraps);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
